[src/mlp_pkg.sv]
`default_nettype none

package mlp_pkg;

    // network shape and word widths
    localparam int NUM_INPUTS = 7;
    localparam int NUM_HIDDEN = 2;
    localparam int WORD_WIDTH = 16;

    localparam int FEAT_PORTS = 7;
    localparam int FEAT_W     = 16;
    localparam int PVAL_W     = 16;
    localparam int IDX_W      = 5;
    localparam int OUT_W      = 18;

    // weight store layout
    localparam int STORE_DEPTH = NUM_INPUTS * NUM_HIDDEN + 2 * NUM_HIDDEN + 1;
    localparam int STORE_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int HBIAS_BASE  = NUM_INPUTS * NUM_HIDDEN;
    localparam int OWGT_BASE   = HBIAS_BASE + NUM_HIDDEN;
    localparam int OBIAS_ADDR  = OWGT_BASE + NUM_HIDDEN;

    // beat kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // pipeline depth
    localparam int LANE_STAGES  = 6;
    localparam int MERGE_STAGES = 3;
    localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;

    // hidden lane datapath widths
    localparam int PROD_W = FEAT_W + WORD_WIDTH;
    localparam int PAIRS  = (NUM_INPUTS + 1) / 2;
    localparam int PAIR_W = PROD_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(NUM_INPUTS) + 1;
    localparam int P_W    = ACC_W - 7;

    // activation table range
    localparam int SIG_LOW  = -140;
    localparam int SIG_HIGH = 400;
    localparam int SIG_SPAN = SIG_HIGH - SIG_LOW + 1;
    localparam int SEG_SIZE = 256;
    localparam int SEG_W    = 8;
    localparam int U_W      = 10;
    localparam int H_W      = 9;
    localparam logic [H_W-1:0] H_FULL = H_W'(256);

    // output merge widths
    localparam int HPROD_W = H_W + 1 + WORD_WIDTH;
    localparam int OSUM_W  = HPROD_W + $clog2(NUM_HIDDEN) + 1;
    localparam int Y_W     = OSUM_W - 7;
    localparam int YX_W    = (Y_W > OUT_W) ? Y_W : OUT_W + 1;
    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(1 << (OUT_W - 1));

    localparam logic [63:0] Q40_ONE = 64'd1 << 40;

    typedef logic [SEG_SIZE-1:0][H_W-1:0]            t_seg_tab;
    typedef logic [FEAT_PORTS-1:0][FEAT_W-1:0]       t_feat_all;
    typedef logic [NUM_INPUTS-1:0][FEAT_W-1:0]       t_feat_vec;
    typedef logic [NUM_INPUTS-1:0][WORD_WIDTH-1:0]   t_wcol_vec;
    typedef logic [NUM_HIDDEN-1:0][WORD_WIDTH-1:0]   t_owgt_vec;
    typedef logic [NUM_HIDDEN-1:0][H_W-1:0]          t_hid_vec;

    // per-stage load enables, lanes first then merge
    typedef struct packed {
        logic [LANE_STAGES-1:0]  lane_en;
        logic [MERGE_STAGES-1:0] merge_en;
    } t_pipe_ctl;

    // shift-subtract division, quotient limited to qbits bits
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den,
                                         input int qbits);
        logic [63:0] rem;
        logic [63:0] q;
        rem = num;
        q   = '0;
        for (int b = qbits - 1; b >= 0; b--) begin
            if ((rem >> b) >= den) begin
                rem  = rem - (den << b);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // q40 product from 20-bit halves
    function automatic logic [63:0] qmul40(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] xh, xl, yh, yl;
        xh = x >> 20;
        xl = x & 64'hFFFFF;
        yh = y >> 20;
        yl = y & 64'hFFFFF;
        return xh * yh + ((xh * yl + xl * yh) >> 20) + ((xl * yl) >> 40);
    endfunction

    // e^(t/128) in q40: series for e^(t/1024), then three squarings
    function automatic logic [63:0] exp_q40(input logic [63:0] t);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = Q40_ONE;
        term = Q40_ONE;
        for (int k = 1; k <= 24; k++) begin
            term = udiv((term * t) >> 10, 64'(k), 44);
            sum  = sum + term;
        end
        for (int k = 0; k < 3; k++) begin
            sum = qmul40(sum, sum);
        end
        return sum;
    endfunction

    // scaled sigmoid for p inside the table range
    function automatic logic [H_W-1:0] sig_value(input int p);
        logic [63:0] e;
        logic [63:0] d;
        int          n;
        n = 384 - 3 * p;
        if (n >= 0) begin
            e = exp_q40(64'(n));
            d = Q40_ONE + e;
            return H_W'(udiv((64'd1 << 49) + d, d << 1, 10));
        end
        e = exp_q40(64'(-n));
        d = Q40_ONE + e;
        return H_W'(udiv((e << 9) + d, d << 1, 10));
    endfunction

    function automatic t_seg_tab sig_segment(input int base);
        t_seg_tab tab;
        tab = '0;
        for (int i = 0; i < SEG_SIZE; i++) begin
            if (base + i < SIG_SPAN) begin
                tab[i] = sig_value(SIG_LOW + base + i);
            end
        end
        return tab;
    endfunction

    // activation table in three segments of the offset p - SIG_LOW
    localparam t_seg_tab SIG_TAB0 = sig_segment(0);
    localparam t_seg_tab SIG_TAB1 = sig_segment(SEG_SIZE);
    localparam t_seg_tab SIG_TAB2 = sig_segment(2 * SEG_SIZE);

    localparam logic [1:0] SEG_0 = 2'd0;
    localparam logic [1:0] SEG_1 = 2'd1;
    localparam logic [1:0] SEG_2 = 2'd2;

endpackage

`default_nettype wire

[src/mlp_lane.sv]
`default_nettype none

module mlp_lane (
    input  wire logic                               i_clk,
    input  wire mlp_pkg::t_pipe_ctl                 i_ctl,
    input  wire mlp_pkg::t_feat_vec                 i_features,
    input  wire mlp_pkg::t_wcol_vec                 i_weights,
    input  wire logic [mlp_pkg::WORD_WIDTH-1:0]     i_bias,
    output logic      [mlp_pkg::H_W-1:0]            o_hidden
);

    logic signed [mlp_pkg::PROD_W-1:0] r_prod [mlp_pkg::NUM_INPUTS];
    logic signed [mlp_pkg::PROD_W-1:0] n_prod [mlp_pkg::NUM_INPUTS];
    logic signed [mlp_pkg::PAIR_W-1:0] r_pair [mlp_pkg::PAIRS];
    logic signed [mlp_pkg::PAIR_W-1:0] n_pair [mlp_pkg::PAIRS];
    logic signed [mlp_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic signed [mlp_pkg::P_W-1:0]    n_p;
    logic        [mlp_pkg::U_W-1:0]    r_u, n_u;
    logic                              r_lo, n_lo, r_hi, n_hi;
    logic        [mlp_pkg::H_W-1:0]    r_t0, r_t1, r_t2;
    logic        [1:0]                 r_seg;
    logic                              r_lo2, r_hi2;
    logic        [mlp_pkg::H_W-1:0]    r_h, n_h;

    // feature times weight, one multiplier per input
    always_comb begin
        for (int j = 0; j < mlp_pkg::NUM_INPUTS; j++) begin
            n_prod[j] = mlp_pkg::PROD_W'($signed(i_features[j]))
                      * mlp_pkg::PROD_W'($signed(i_weights[j]));
        end
    end

    // pairwise sums of the products
    always_comb begin
        for (int k = 0; k < mlp_pkg::PAIRS; k++) begin
            n_pair[k] = mlp_pkg::PAIR_W'(r_prod[2 * k]);
            if (2 * k + 1 < mlp_pkg::NUM_INPUTS) begin
                n_pair[k] = n_pair[k] + mlp_pkg::PAIR_W'(r_prod[2 * k + 1]);
            end
        end
    end

    // dot product
    always_comb begin
        n_acc = '0;
        for (int k = 0; k < mlp_pkg::PAIRS; k++) begin
            n_acc = n_acc + mlp_pkg::ACC_W'(r_pair[k]);
        end
    end

    // shift, bias, range flags and table offset
    always_comb begin
        n_p  = mlp_pkg::P_W'(r_acc >>> 8) + mlp_pkg::P_W'($signed(i_bias));
        n_lo = n_p < mlp_pkg::P_W'(mlp_pkg::SIG_LOW);
        n_hi = n_p > mlp_pkg::P_W'(mlp_pkg::SIG_HIGH);
        n_u  = mlp_pkg::U_W'(n_p - mlp_pkg::P_W'(mlp_pkg::SIG_LOW));
    end

    // pick the segment, saturate outside the table range
    always_comb begin
        case (r_seg)
            mlp_pkg::SEG_0: n_h = r_t0;
            mlp_pkg::SEG_1: n_h = r_t1;
            mlp_pkg::SEG_2: n_h = r_t2;
            default:        n_h = r_t2;
        endcase
        if (r_lo2) begin
            n_h = '0;
        end else if (r_hi2) begin
            n_h = mlp_pkg::H_FULL;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.lane_en[0]) begin
            r_prod <= n_prod;
        end
        if (i_ctl.lane_en[1]) begin
            r_pair <= n_pair;
        end
        if (i_ctl.lane_en[2]) begin
            r_acc <= n_acc;
        end
        if (i_ctl.lane_en[3]) begin
            r_u  <= n_u;
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_ctl.lane_en[4]) begin
            r_t0  <= mlp_pkg::SIG_TAB0[r_u[mlp_pkg::SEG_W-1:0]];
            r_t1  <= mlp_pkg::SIG_TAB1[r_u[mlp_pkg::SEG_W-1:0]];
            r_t2  <= mlp_pkg::SIG_TAB2[r_u[mlp_pkg::SEG_W-1:0]];
            r_seg <= r_u[mlp_pkg::U_W-1:mlp_pkg::SEG_W];
            r_lo2 <= r_lo;
            r_hi2 <= r_hi;
        end
        if (i_ctl.lane_en[5]) begin
            r_h <= n_h;
        end
    end

    assign o_hidden = r_h;

endmodule

`default_nettype wire

[src/mlp_merge.sv]
`default_nettype none

module mlp_merge (
    input  wire logic                               i_clk,
    input  wire mlp_pkg::t_pipe_ctl                 i_ctl,
    input  wire mlp_pkg::t_hid_vec                  i_hidden,
    input  wire mlp_pkg::t_owgt_vec                 i_owgt,
    input  wire logic [mlp_pkg::WORD_WIDTH-1:0]     i_obias,
    output logic      [mlp_pkg::OUT_W-1:0]          o_output_value
);

    logic signed [mlp_pkg::HPROD_W-1:0] r_hprod [mlp_pkg::NUM_HIDDEN];
    logic signed [mlp_pkg::HPROD_W-1:0] n_hprod [mlp_pkg::NUM_HIDDEN];
    logic signed [mlp_pkg::OSUM_W-1:0]  r_osum, n_osum;
    logic signed [mlp_pkg::YX_W-1:0]    n_y;
    logic        [mlp_pkg::OUT_W-1:0]   r_out, n_out;

    // hidden value times output weight, one multiplier per lane
    always_comb begin
        for (int i = 0; i < mlp_pkg::NUM_HIDDEN; i++) begin
            n_hprod[i] = mlp_pkg::HPROD_W'($signed({1'b0, i_hidden[i]}))
                       * mlp_pkg::HPROD_W'($signed(i_owgt[i]));
        end
    end

    // sum over the lanes
    always_comb begin
        n_osum = '0;
        for (int i = 0; i < mlp_pkg::NUM_HIDDEN; i++) begin
            n_osum = n_osum + mlp_pkg::OSUM_W'(r_hprod[i]);
        end
    end

    // shift, output bias and saturation
    always_comb begin
        n_y = mlp_pkg::YX_W'(r_osum >>> 8) + mlp_pkg::YX_W'($signed(i_obias));
        if (n_y > mlp_pkg::YX_W'(mlp_pkg::OUT_MAX)) begin
            n_out = mlp_pkg::OUT_W'(mlp_pkg::OUT_MAX);
        end else if (n_y < mlp_pkg::YX_W'(mlp_pkg::OUT_MIN)) begin
            n_out = mlp_pkg::OUT_W'(mlp_pkg::OUT_MIN);
        end else begin
            n_out = mlp_pkg::OUT_W'(n_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.merge_en[0]) begin
            r_hprod <= n_hprod;
        end
        if (i_ctl.merge_en[1]) begin
            r_osum <= n_osum;
        end
        if (i_ctl.merge_en[2]) begin
            r_out <= n_out;
        end
    end

    assign o_output_value = r_out;

endmodule

`default_nettype wire

[src/mlp_forward_inference.sv]
`default_nettype none

// a sample beat passes through 6 lane and 3 merge stages before its result shows on the output
// throughput: one sample per cycle while not stalled; each stage advances when the next one is free or empty
// a load beat waits until no sample is in flight, then writes its word
// reset clears the stage valid bits only; weight words are undefined until loaded

module mlp_forward_inference (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_kind,
    input  wire logic [mlp_pkg::IDX_W-1:0]           i_param_index,
    input  wire logic signed [mlp_pkg::PVAL_W-1:0]   i_param_value,
    input  wire logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_0,
    input  wire logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_1,
    input  wire logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_2,
    input  wire logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_3,
    input  wire logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_4,
    input  wire logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_5,
    input  wire logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_6,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [mlp_pkg::OUT_W-1:0]         o_output_value
);

    logic [mlp_pkg::WORD_WIDTH-1:0] r_weight [mlp_pkg::STORE_DEPTH];
    logic [mlp_pkg::NUM_STAGES-1:0] r_vld;
    logic [mlp_pkg::NUM_STAGES:0]   w_rdy;
    logic                           w_busy;
    logic                           w_load;
    mlp_pkg::t_pipe_ctl             w_ctl;
    mlp_pkg::t_feat_all             w_feat_all;
    mlp_pkg::t_feat_vec             w_feat;
    mlp_pkg::t_hid_vec              w_hidden;
    mlp_pkg::t_owgt_vec             w_owgt;
    logic [mlp_pkg::OUT_W-1:0]      w_out;

    // ready chain from the output back to the input stage
    always_comb begin
        w_rdy[mlp_pkg::NUM_STAGES] = !i_stall;
        for (int k = mlp_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k + 1];
        end
    end

    // loads hold off while any sample is still in flight
    assign w_busy  = |r_vld;
    assign o_stall = !w_rdy[0] || ((i_kind == mlp_pkg::KIND_LOAD) && w_busy);
    assign w_load  = i_valid && !o_stall && (i_kind == mlp_pkg::KIND_LOAD);

    assign w_ctl.lane_en  = w_rdy[mlp_pkg::LANE_STAGES-1:0];
    assign w_ctl.merge_en = w_rdy[mlp_pkg::NUM_STAGES-1:mlp_pkg::LANE_STAGES];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid && (i_kind == mlp_pkg::KIND_SAMPLE);
            end
            for (int k = 1; k < mlp_pkg::NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    // weight store write
    always_ff @(posedge i_clk) begin
        if (w_load && (32'(i_param_index) < mlp_pkg::STORE_DEPTH)) begin
            r_weight[mlp_pkg::STORE_W'(i_param_index)] <=
                mlp_pkg::WORD_WIDTH'(i_param_value);
        end
    end

    assign w_feat_all = {i_feature_6, i_feature_5, i_feature_4, i_feature_3,
                         i_feature_2, i_feature_1, i_feature_0};
    assign w_feat     = w_feat_all[mlp_pkg::NUM_INPUTS-1:0];

    // one lane per hidden node
    for (genvar gi = 0; gi < mlp_pkg::NUM_HIDDEN; gi++) begin : g_lane
        mlp_pkg::t_wcol_vec w_col;

        for (genvar gj = 0; gj < mlp_pkg::NUM_INPUTS; gj++) begin : g_col
            assign w_col[gj] = r_weight[gj * mlp_pkg::NUM_HIDDEN + gi];
        end

        assign w_owgt[gi] = r_weight[mlp_pkg::OWGT_BASE + gi];

        mlp_lane u_lane (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_features (w_feat),
            .i_weights  (w_col),
            .i_bias     (r_weight[mlp_pkg::HBIAS_BASE + gi]),
            .o_hidden   (w_hidden[gi])
        );
    end

    // output layer
    mlp_merge u_merge (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_hidden       (w_hidden),
        .i_owgt         (w_owgt),
        .i_obias        (r_weight[mlp_pkg::OBIAS_ADDR]),
        .o_output_value (w_out)
    );

    assign o_valid        = r_vld[mlp_pkg::NUM_STAGES-1];
    assign o_output_value = w_out;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [63:0] FX_ONE = 64'd1 << 40;

    typedef logic signed [mlp_pkg::FEAT_W-1:0] t_features [mlp_pkg::FEAT_PORTS];

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic                                i_kind;
    logic [mlp_pkg::IDX_W-1:0]           i_param_index;
    logic signed [mlp_pkg::PVAL_W-1:0]   i_param_value;
    logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_0;
    logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_1;
    logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_2;
    logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_3;
    logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_4;
    logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_5;
    logic signed [mlp_pkg::FEAT_W-1:0]   i_feature_6;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic signed [mlp_pkg::OUT_W-1:0]    o_output_value;

    // shadow copy of the weight store and outputs still owed by the block
    longint                              weight_mem [mlp_pkg::STORE_DEPTH];
    logic signed [mlp_pkg::OUT_W-1:0]    expected_outputs [$];

    int  fail_count   = 0;
    int  cycle_count  = 0;
    bit  idle_on      = 1'b1;
    int  hold_request = 0;
    int  burst_left   = 0;

    mlp_forward_inference dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_param_index  (i_param_index),
        .i_param_value  (i_param_value),
        .i_feature_0    (i_feature_0),
        .i_feature_1    (i_feature_1),
        .i_feature_2    (i_feature_2),
        .i_feature_3    (i_feature_3),
        .i_feature_4    (i_feature_4),
        .i_feature_5    (i_feature_5),
        .i_feature_6    (i_feature_6),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_output_value (o_output_value)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // q40 square built from 20-bit halves, partial terms floored
    function automatic logic [63:0] fx_square(input logic [63:0] x);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = x >> 20;
        lo = x & 64'hFFFFF;
        return hi * hi + ((hi * lo + lo * hi) >> 20) + ((lo * lo) >> 40);
    endfunction

    // e^(t/128) in q40: series of e^(t/1024) up to the 24th-power term, squared three times
    function automatic logic [63:0] exp_fixed(input logic [63:0] t);
        logic [63:0] total;
        logic [63:0] term;
        total = FX_ONE;
        term  = FX_ONE;
        for (int k = 1; k <= 24; k++) begin
            term  = (term * t) / (64'd1024 * 64'(k));
            total = total + term;
        end
        for (int k = 0; k < 3; k++) begin
            total = fx_square(total);
        end
        return total;
    endfunction

    // round(256 / (1 + e^(3 - 6p/256))) clamped to 0..256
    function automatic longint scaled_sigmoid(input longint p);
        longint      n;
        logic [63:0] e;
        logic [63:0] d;
        if (p < mlp_pkg::SIG_LOW) return 0;
        if (p > mlp_pkg::SIG_HIGH) return 256;
        n = 384 - 3 * p;
        if (n >= 0) begin
            e = exp_fixed(64'(n));
            d = FX_ONE + e;
            return longint'(((64'd1 << 49) + d) / (d << 1));
        end
        e = exp_fixed(64'(-n));
        d = FX_ONE + e;
        return longint'(((e << 9) + d) / (d << 1));
    endfunction

    // full forward pass over the shadow weights
    function automatic logic signed [mlp_pkg::OUT_W-1:0] network_output(
        input t_features feats);
        longint acc;
        longint y;
        longint hid [mlp_pkg::NUM_HIDDEN];
        for (int i = 0; i < mlp_pkg::NUM_HIDDEN; i++) begin
            acc = 0;
            for (int j = 0; j < mlp_pkg::NUM_INPUTS; j++) begin
                acc += longint'(feats[j]) * weight_mem[j * mlp_pkg::NUM_HIDDEN + i];
            end
            hid[i] = scaled_sigmoid((acc >>> 8) + weight_mem[mlp_pkg::HBIAS_BASE + i]);
        end
        acc = 0;
        for (int i = 0; i < mlp_pkg::NUM_HIDDEN; i++) begin
            acc += hid[i] * weight_mem[mlp_pkg::OWGT_BASE + i];
        end
        y = (acc >>> 8) + weight_mem[mlp_pkg::OBIAS_ADDR];
        if (y > mlp_pkg::OUT_MAX) y = mlp_pkg::OUT_MAX;
        if (y < mlp_pkg::OUT_MIN) y = mlp_pkg::OUT_MIN;
        return mlp_pkg::OUT_W'(y);
    endfunction

    // signed word of random magnitude, with an occasional extreme
    function automatic logic signed [15:0] rand_word();
        logic signed [15:0] r;
        int                 w;
        case ($urandom_range(0, 11))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: begin
                w = $urandom_range(1, 16);
                r = 16'($urandom);
                return r >>> (16 - w);
            end
        endcase
    endfunction

    function automatic t_features random_features();
        t_features f;
        for (int j = 0; j < mlp_pkg::FEAT_PORTS; j++) f[j] = rand_word();
        return f;
    endfunction

    function automatic t_features flat_features(input int v);
        t_features f;
        for (int j = 0; j < mlp_pkg::FEAT_PORTS; j++) f[j] = mlp_pkg::FEAT_W'(v);
        return f;
    endfunction

    // offer one beat, wait for it to be taken, then update the prediction
    task automatic send_beat(input logic kind, input logic [mlp_pkg::IDX_W-1:0] idx,
                             input logic signed [mlp_pkg::PVAL_W-1:0] value,
                             input t_features feats);
        int         gap;
        logic [mlp_pkg::WORD_WIDTH-1:0] word;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_param_index <= idx;
        i_param_value <= value;
        i_feature_0   <= feats[0];
        i_feature_1   <= feats[1];
        i_feature_2   <= feats[2];
        i_feature_3   <= feats[3];
        i_feature_4   <= feats[4];
        i_feature_5   <= feats[5];
        i_feature_6   <= feats[6];
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (kind == mlp_pkg::KIND_LOAD) begin
            if (idx < mlp_pkg::STORE_DEPTH) begin
                word = mlp_pkg::WORD_WIDTH'(value);
                weight_mem[idx] = longint'($signed(word));
            end
        end else begin
            expected_outputs.push_back(network_output(feats));
        end
    endtask

    task automatic load_word(input int idx, input int value);
        send_beat(mlp_pkg::KIND_LOAD, mlp_pkg::IDX_W'(idx), mlp_pkg::PVAL_W'(value),
                  random_features());
    endtask

    task automatic send_sample(input t_features feats);
        send_beat(mlp_pkg::KIND_SAMPLE, mlp_pkg::IDX_W'($urandom),
                  mlp_pkg::PVAL_W'($urandom), feats);
    endtask

    // receiver: long holds on request, otherwise random stall bursts
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            i_stall <= 1'b1;
            hold_request--;
        end else if (burst_left > 0) begin
            i_stall <= 1'b1;
            burst_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            burst_left = $urandom_range(0, 4);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // compare each output beat with the oldest prediction
    always @(posedge i_clk) begin : check_outputs
        logic signed [mlp_pkg::OUT_W-1:0] want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_outputs.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected output beat: got %0d", o_output_value);
                fail_count++;
            end else begin
                want = expected_outputs.pop_front();
                if (o_output_value !== want) begin
                    if (fail_count < 10)
                        $display("output mismatch: expected %0d got %0d", want, o_output_value);
                    fail_count++;
                end
            end
        end
    end

    // every word written, hidden weights cycle a pattern with both extremes, biases near the clamp edges
    task automatic test_full_load();
        int pattern [8];
        pattern = '{32767, -32768, 1, -1, 0, 256, -256, 4660};
        for (int k = 0; k < mlp_pkg::HBIAS_BASE; k++) load_word(k, pattern[k % 8]);
        load_word(mlp_pkg::HBIAS_BASE, -141);
        load_word(mlp_pkg::HBIAS_BASE + 1, -140);
        load_word(mlp_pkg::OWGT_BASE, 32767);
        load_word(mlp_pkg::OWGT_BASE + 1, 32767);
        load_word(mlp_pkg::OBIAS_ADDR, 32767);
    endtask

    task automatic test_extreme_samples();
        t_features alt;
        send_sample(flat_features(0));
        send_sample(flat_features(32767));
        send_sample(flat_features(-32768));
        for (int j = 0; j < mlp_pkg::FEAT_PORTS; j++)
            alt[j] = (j % 2) ? mlp_pkg::FEAT_W'(-32768) : mlp_pkg::FEAT_W'(32767);
        send_sample(alt);
    endtask

    // zero features make the hidden sum equal the bias: walk the sigmoid edges
    task automatic test_activation_edges();
        load_word(mlp_pkg::HBIAS_BASE, 400);
        load_word(mlp_pkg::HBIAS_BASE + 1, 401);
        send_sample(flat_features(0));
        load_word(mlp_pkg::HBIAS_BASE, 128);
        load_word(mlp_pkg::HBIAS_BASE + 1, 129);
        send_sample(flat_features(0));
        // negative output: both output weights and the output bias at their minimum
        load_word(mlp_pkg::OWGT_BASE, -32768);
        load_word(mlp_pkg::OWGT_BASE + 1, -32768);
        load_word(mlp_pkg::OBIAS_ADDR, -32768);
        load_word(mlp_pkg::HBIAS_BASE, 401);
        send_sample(flat_features(0));
    endtask

    // loads past the end of the store change nothing
    task automatic test_ignored_index();
        load_word(mlp_pkg::STORE_DEPTH, 32767);
        load_word((1 << mlp_pkg::IDX_W) - 1, -32768);
        send_sample(flat_features(0));
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (i % 140 == 0) begin
                for (int k = 0; k < mlp_pkg::STORE_DEPTH; k++) load_word(k, rand_word());
            end else if ($urandom_range(0, 6) == 0) begin
                if ($urandom_range(0, 4) == 0)
                    load_word($urandom_range(mlp_pkg::STORE_DEPTH, (1 << mlp_pkg::IDX_W) - 1),
                              rand_word());
                else
                    load_word($urandom_range(0, mlp_pkg::STORE_DEPTH - 1), rand_word());
            end else begin
                send_sample(random_features());
            end
        end
    endtask

    // receiver holds off while samples keep coming, so the pipeline backs up
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        hold_request = 150;
        repeat (40) send_sample(random_features());
    endtask

    task automatic test_steady_stream(input int n_items);
        idle_on = 1'b0;
        repeat (n_items) send_sample(random_features());
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_kind        <= mlp_pkg::KIND_LOAD;
        i_param_index <= '0;
        i_param_value <= '0;
        i_feature_0   <= '0;
        i_feature_1   <= '0;
        i_feature_2   <= '0;
        i_feature_3   <= '0;
        i_feature_4   <= '0;
        i_feature_5   <= '0;
        i_feature_6   <= '0;
        for (int k = 0; k < mlp_pkg::STORE_DEPTH; k++) weight_mem[k] = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_load();
        test_extreme_samples();
        test_activation_edges();
        test_ignored_index();
        test_random_traffic(340);
        test_output_backpressure();
        test_steady_stream(40);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (2 * mlp_pkg::NUM_STAGES + 4) @(posedge i_clk);
        if (fail_count == 0 && expected_outputs.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
